[rtl/tsm_pkg.sv]
`default_nettype none

package tsm_pkg;

    localparam int LIST_DEPTH  = 32;
    localparam int VALUE_WIDTH = 32;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_MERGE  = 2'd2;

    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [VALUE_WIDTH-1:0] word_t;

endpackage

`default_nettype wire

[rtl/tsm_ram.sv]
`default_nettype none

module tsm_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/two_way_sorted_merge_core.sv]
`default_nettype none
// channel   dir  handshake             payload
// input     in   in_valid / in_stall   func, value
// output    out  out_valid / out_stall value_res, last, empty_res, dropped
//
// Loads are accepted back to back.
// A merge steps through accept, ST_PRIME for the RAM read, then one beat per
// cycle unless out_stall holds it, from the head compare loop over the two RAMs.
// A merge of two empty lists goes to ST_EMPTY, which registers its single beat.
// Reset clears counts, drop flag and control; the list RAMs are not cleared.
// out_stall freezes the compare loop; in_stall is high for the whole merge.

module two_way_sorted_merge_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          func,
    input  wire logic signed [tsm_pkg::VALUE_WIDTH-1:0] value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [tsm_pkg::VALUE_WIDTH-1:0]   value_res,
    output logic                                     last,
    output logic                                     empty_res,
    output logic                                     dropped
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PRIME = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam tsm_pkg::cnt_t FULL = tsm_pkg::CNT_W'(tsm_pkg::LIST_DEPTH);

    logic [1:0]    state_reg, state_next;
    tsm_pkg::cnt_t count_a_reg, count_a_next;
    tsm_pkg::cnt_t count_b_reg, count_b_next;
    tsm_pkg::cnt_t i_reg, i_next;
    tsm_pkg::cnt_t j_reg, j_next;
    logic          drop_reg, drop_next;

    logic           out_valid_reg, out_valid_next;
    tsm_pkg::word_t out_value_reg, out_value_next;
    logic           out_last_reg, out_last_next;
    logic           out_empty_reg, out_empty_next;
    logic           out_drop_reg, out_drop_next;

    logic           wr_a, wr_b;
    logic           rd_en_a, rd_en_b;
    tsm_pkg::idx_t  rd_addr_a, rd_addr_b;
    tsm_pkg::word_t head_a, head_b;

    logic           in_beat, slot_free;
    tsm_pkg::cnt_t  i_inc, j_inc;
    logic           have_a, have_b, take_a, emit_last;

    assign in_beat   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign i_inc     = i_reg + tsm_pkg::CNT_W'(1);
    assign j_inc     = j_reg + tsm_pkg::CNT_W'(1);
    assign have_a    = i_reg != count_a_reg;
    assign have_b    = j_reg != count_b_reg;
    assign take_a    = have_a && (!have_b || ($signed(head_a) < $signed(head_b)));
    assign emit_last = take_a ? ((i_inc == count_a_reg) && !have_b)
                              : ((j_inc == count_b_reg) && !have_a);

    assign wr_a = in_beat && (func == tsm_pkg::FUNC_LOAD_A) && (count_a_reg != FULL);
    assign wr_b = in_beat && (func == tsm_pkg::FUNC_LOAD_B) && (count_b_reg != FULL);

    tsm_ram #(
        .DEPTH(tsm_pkg::LIST_DEPTH),
        .WIDTH(tsm_pkg::VALUE_WIDTH)
    ) u_ram_a (
        .clk    (clk),
        .wr_en  (wr_a),
        .wr_addr(count_a_reg[tsm_pkg::IDX_W-1:0]),
        .wr_data(value),
        .rd_en  (rd_en_a),
        .rd_addr(rd_addr_a),
        .rd_data(head_a)
    );

    tsm_ram #(
        .DEPTH(tsm_pkg::LIST_DEPTH),
        .WIDTH(tsm_pkg::VALUE_WIDTH)
    ) u_ram_b (
        .clk    (clk),
        .wr_en  (wr_b),
        .wr_addr(count_b_reg[tsm_pkg::IDX_W-1:0]),
        .wr_data(value),
        .rd_en  (rd_en_b),
        .rd_addr(rd_addr_b),
        .rd_data(head_b)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_drop_next  = out_drop_reg;
        rd_en_a        = 1'b0;
        rd_en_b        = 1'b0;
        rd_addr_a      = '0;
        rd_addr_b      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (func)
                        tsm_pkg::FUNC_LOAD_A:
                        begin
                            if (wr_a)
                                count_a_next = count_a_reg + tsm_pkg::CNT_W'(1);
                            else
                                drop_next = 1'b1;
                        end
                        tsm_pkg::FUNC_LOAD_B:
                        begin
                            if (wr_b)
                                count_b_next = count_b_reg + tsm_pkg::CNT_W'(1);
                            else
                                drop_next = 1'b1;
                        end
                        tsm_pkg::FUNC_MERGE:
                        begin
                            i_next = '0;
                            j_next = '0;
                            if ((count_a_reg == '0) && (count_b_reg == '0))
                            begin
                                state_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en_a    = 1'b1;
                                rd_en_b    = 1'b1;
                                state_next = ST_PRIME;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PRIME:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = take_a ? head_a : head_b;
                    out_last_next  = emit_last;
                    out_empty_next = 1'b0;
                    out_drop_next  = drop_reg;
                    if (take_a)
                    begin
                        i_next    = i_inc;
                        rd_en_a   = 1'b1;
                        rd_addr_a = i_inc[tsm_pkg::IDX_W-1:0];
                    end
                    else
                    begin
                        j_next    = j_inc;
                        rd_en_b   = 1'b1;
                        rd_addr_b = j_inc[tsm_pkg::IDX_W-1:0];
                    end
                    if (emit_last)
                    begin
                        count_a_next = '0;
                        count_b_next = '0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                    out_drop_next  = drop_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_drop_reg  <= out_drop_next;
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign value_res = out_value_reg;
    assign last      = out_last_reg;
    assign empty_res = out_empty_reg;
    assign dropped   = out_drop_reg;

endmodule

`default_nettype wire

[rtl/tsm_checker.sv]
`default_nettype none

module tsm_checker (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   in_valid,
    input wire logic                                   in_stall,
    input wire logic [1:0]                             func,
    input wire logic                                   out_valid,
    input wire logic                                   out_stall,
    input wire logic signed [tsm_pkg::VALUE_WIDTH-1:0] value_res,
    input wire logic                                   last,
    input wire logic                                   empty_res,
    input wire logic                                   dropped
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_res) && $stable(last)
            && $stable(empty_res) && $stable(dropped))
        else $error("stalled output beat changed");

    // merge request blocks input next cycle
    a_merge_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == tsm_pkg::FUNC_MERGE) |=> in_stall)
        else $error("input not stalled after merge request");

    // a merge is still running while a beat that is not last is shown
    a_mid_merge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |-> in_stall)
        else $error("input accepted in the middle of a merge");

    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last && (value_res == '0))
        else $error("empty beat not last or nonzero");

endmodule

bind two_way_sorted_merge_core tsm_checker u_tsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value_res(value_res),
    .last     (last),
    .empty_res(empty_res),
    .dropped  (dropped)
);

`default_nettype wire
